/* hw/rtl/lrf_pkg.sv */
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the least rotation finder: item payloads,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrf_pkg;

  // default buffer depth
  localparam int unsigned MAX_LEN_DEF = 64;

  // element width
  localparam int unsigned DATA_W = 32;

  // input item
  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     final_element;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [DATA_W-1:0] rotated_element;
    logic                     final_result;
    logic                     overflowed;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CMP_RD,
    ST_CMP_EV,
    ST_OUT_INIT,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // store the incoming item
    logic setup;      // start the offset search
    logic take_best;  // current offset becomes best
    logic next_off;   // advance to the next candidate offset
    logic next_k;     // advance both read pointers
    logic out_init;   // point at the best offset for readout
    logic rd;         // read the buffer at both pointers
    logic emit;       // present one result
    logic clear;      // sequence done, empty the buffer
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_one;     // only one stored element
    logic lt;        // candidate element below best element
    logic gt;        // candidate element above best element
    logic k_last;    // position is the last of the sequence
    logic off_last;  // candidate offset is the last one
  } sts_t;

endpackage

/* hw/rtl/lrf_ctrl.sv */
// ----------------------------------------------------------------------------
// lrf_ctrl
// Sequencer of the least rotation finder: load, offset search, readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            final_i,
  input  lrf_pkg::sts_t   sts_i,
  output lrf_pkg::cmd_t   cmd_o,
  output logic            busy
);

  lrf_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrf_pkg::ST_IDLE: begin
        if (start && final_i) state_d = lrf_pkg::ST_SETUP;
      end
      lrf_pkg::ST_SETUP: begin
        state_d = sts_i.n_one ? lrf_pkg::ST_OUT_INIT : lrf_pkg::ST_CMP_RD;
      end
      lrf_pkg::ST_CMP_RD: begin
        state_d = lrf_pkg::ST_CMP_EV;
      end
      lrf_pkg::ST_CMP_EV: begin
        if (sts_i.lt || sts_i.gt || sts_i.k_last) begin
          state_d = sts_i.off_last ? lrf_pkg::ST_OUT_INIT : lrf_pkg::ST_CMP_RD;
        end else begin
          state_d = lrf_pkg::ST_CMP_RD;
        end
      end
      lrf_pkg::ST_OUT_INIT: begin
        state_d = lrf_pkg::ST_OUT_RD;
      end
      lrf_pkg::ST_OUT_RD: begin
        state_d = lrf_pkg::ST_OUT_EMIT;
      end
      lrf_pkg::ST_OUT_EMIT: begin
        state_d = sts_i.k_last ? lrf_pkg::ST_IDLE : lrf_pkg::ST_OUT_RD;
      end
      default: begin
        state_d = lrf_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      lrf_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      lrf_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      lrf_pkg::ST_CMP_RD: begin
        cmd_o.rd = 1'b1;
      end
      lrf_pkg::ST_CMP_EV: begin
        // a decided compare or a full tie ends this candidate
        cmd_o.take_best = sts_i.lt;
        cmd_o.next_off  = sts_i.lt || sts_i.gt || sts_i.k_last;
        cmd_o.next_k    = !(sts_i.lt || sts_i.gt || sts_i.k_last);
      end
      lrf_pkg::ST_OUT_INIT: begin
        cmd_o.out_init = 1'b1;
      end
      lrf_pkg::ST_OUT_RD: begin
        cmd_o.rd = 1'b1;
      end
      lrf_pkg::ST_OUT_EMIT: begin
        cmd_o.emit   = 1'b1;
        cmd_o.next_k = 1'b1;
        cmd_o.clear  = sts_i.k_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/lrf_datapath.sv */
// ----------------------------------------------------------------------------
// lrf_datapath
// Element buffer with two registered read ports, offset and position
// counters, signed element compare and result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrf_datapath #(
  parameter int unsigned MaxLen = lrf_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrf_pkg::in_item_t  in_item_i,
  input  lrf_pkg::cmd_t      cmd_i,
  output lrf_pkg::sts_t      sts_o,
  output lrf_pkg::out_item_t out_item_o,
  output logic               out_strobe_o
);

  localparam int unsigned AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CW = $clog2(MaxLen + 1);

  logic [lrf_pkg::DATA_W-1:0] mem_q [MaxLen];
  logic [lrf_pkg::DATA_W-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] k_q, k_d;
  logic [AW-1:0] off_q, off_d;
  logic [AW-1:0] best_q, best_d;
  logic [AW-1:0] pa_q, pa_d;
  logic [AW-1:0] pb_q, pb_d;

  logic          full;
  logic [CW-1:0] pa_inc, pb_inc, off_inc;
  logic [AW-1:0] pa_wrap, pb_wrap;

  assign full = (count_q == CW'(MaxLen));

  // pointer steps, wrapped below the sequence length
  assign pa_inc  = CW'(pa_q) + CW'(1);
  assign pb_inc  = CW'(pb_q) + CW'(1);
  assign off_inc = CW'(off_q) + CW'(1);
  assign pa_wrap = (pa_inc == count_q) ? '0 : pa_inc[AW-1:0];
  assign pb_wrap = (pb_inc == count_q) ? '0 : pb_inc[AW-1:0];

  // status toward the controller
  assign sts_o.n_one    = (count_q == CW'(1));
  assign sts_o.lt       = $signed(rd_a_q) < $signed(rd_b_q);
  assign sts_o.gt       = $signed(rd_a_q) > $signed(rd_b_q);
  assign sts_o.k_last   = ((k_q + CW'(1)) == count_q);
  assign sts_o.off_last = (off_inc == count_q);

  // buffer write and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[AW-1:0]] <= in_item_i.element;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem_q[pa_q];
      rd_b_q <= mem_q[pb_q];
    end
  end

  // counter next values
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    k_d     = k_q;
    off_d   = off_q;
    best_d  = best_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    if (cmd_i.load) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.setup) begin
      best_d = '0;
      off_d  = AW'(1);
      pa_d   = AW'(1);
      pb_d   = '0;
      k_d    = '0;
    end
    if (cmd_i.next_k) begin
      k_d  = k_q + CW'(1);
      pa_d = pa_wrap;
      pb_d = pb_wrap;
    end
    if (cmd_i.take_best) begin
      best_d = off_q;
    end
    if (cmd_i.next_off) begin
      off_d = off_inc[AW-1:0];
      pa_d  = off_inc[AW-1:0];
      pb_d  = cmd_i.take_best ? off_q : best_q;
      k_d   = '0;
    end
    if (cmd_i.out_init) begin
      pa_d = best_q;
      pb_d = best_q;
      k_d  = '0;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    off_q  <= off_d;
    best_q <= best_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
  end

  // result item
  assign out_strobe_o               = cmd_i.emit;
  assign out_item_o.rotated_element = rd_a_q;
  assign out_item_o.final_result    = sts_o.k_last;
  assign out_item_o.overflowed      = drop_q;

endmodule

/* hw/rtl/least_rotation_finder.sv */
// While idle, one item is loaded per cycle that start is high. After the
// final item: a setup state, then per element compare a read state (the
// single buffer read stage feeding the compare) and an evaluate state, then
// a state to point at the best offset, and per result a read and emit state.
// Throughput: one sequence at a time; busy stays high from the final item to
// the last result, which the receiver must take as it appears.
// ----------------------------------------------------------------------------
// least_rotation_finder
// Loads a sequence of signed elements and emits its lexicographically
// smallest cyclic rotation, earliest offset on a tie. Reset clears the
// controller, element count and drop flag; the buffer is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_rotation_finder #(
  parameter int unsigned MaxLen = lrf_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lrf_pkg::in_item_t  in_item_i,
  output lrf_pkg::out_item_t out_item_o,
  output logic               out_strobe_o
);

  lrf_pkg::cmd_t cmd;
  lrf_pkg::sts_t sts;

  // sequencer
  lrf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .final_i (in_item_i.final_element),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  // buffer and compare
  lrf_datapath #(
    .MaxLen (MaxLen)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_item_i    (in_item_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_item_o   (out_item_o),
    .out_strobe_o (out_strobe_o)
  );

endmodule

/* bench/least_rotation_finder_tb.sv */
// ----------------------------------------------------------------------------
// least_rotation_finder_tb
// Self-checking bench for the least rotation finder. Sequences of signed
// elements go in through the start/busy handshake. An in-bench predictor
// works out the smallest rotation of every sequence, and each strobed result
// is checked against the oldest predicted one. Directed rows come first, then
// random sequences of mixed content and length, including full and
// overflowing buffers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_rotation_finder_tb;

  localparam int unsigned MAX_LEN     = lrf_pkg::MAX_LEN_DEF;
  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  localparam logic signed [lrf_pkg::DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [lrf_pkg::DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

  // kinds of element content in a random sequence
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_EXTREME,
    FILL_PERIODIC
  } fill_e;

  // one directed row, with a typed-in result where it is obvious
  typedef struct {
    lrf_pkg::in_item_t  item;
    bit                 typed;
    lrf_pkg::out_item_t want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  lrf_pkg::in_item_t  in_item = '0;
  lrf_pkg::out_item_t out_item;
  logic               out_strobe;

  // predictor state
  logic signed [lrf_pkg::DATA_W-1:0] held_elements[$];
  bit                                drop_seen;
  lrf_pkg::out_item_t                pending_rotation_q[$];

  stim_row_t stim_rows[$];

  int unsigned        cycle_count = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        results_checked = 0;
  int unsigned        runs_done = 0;
  int unsigned        overflow_runs = 0;
  int unsigned        longest_run = 0;
  lrf_pkg::out_item_t oldest_r;

  least_rotation_finder #(
    .MaxLen(MAX_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_item_i   (in_item),
    .out_item_o  (out_item),
    .out_strobe_o(out_strobe)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_rotation_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // offset of the smallest rotation of the held elements, earliest on a tie
  function automatic int unsigned least_offset();
    int unsigned n;
    int unsigned best;
    logic signed [lrf_pkg::DATA_W-1:0] cand;
    logic signed [lrf_pkg::DATA_W-1:0] kept;
    n = held_elements.size();
    best = 0;
    for (int unsigned off = 1; off < n; off++) begin
      for (int unsigned k = 0; k < n; k++) begin
        cand = held_elements[(off + k) % n];
        kept = held_elements[(best + k) % n];
        if (cand < kept) begin
          best = off;
          break;
        end
        if (cand > kept) break;
      end
    end
    return best;
  endfunction

  // update the predictor with one accepted item
  task automatic predict_rotation(input lrf_pkg::in_item_t it, input bit typed,
                                  input lrf_pkg::out_item_t want);
    int unsigned n;
    int unsigned best;
    lrf_pkg::out_item_t r;
    if (held_elements.size() < MAX_LEN) held_elements.push_back(it.element);
    else drop_seen = 1'b1;
    if (it.final_element) begin
      n = held_elements.size();
      if (typed) begin
        pending_rotation_q.push_back(want);
      end else begin
        best = least_offset();
        for (int unsigned k = 0; k < n; k++) begin
          r.rotated_element = held_elements[(best + k) % n];
          r.final_result    = (k == n - 1);
          r.overflowed      = drop_seen;
          pending_rotation_q.push_back(r);
        end
      end
      runs_done++;
      if (drop_seen) overflow_runs++;
      if (n > longest_run) longest_run = n;
      held_elements.delete();
      drop_seen = 1'b0;
    end
  endtask

  // present one item, optionally after random idle cycles, and wait for it to go in
  task automatic send_item(input lrf_pkg::in_item_t it, input bit typed,
                           input lrf_pkg::out_item_t want, input bit idle_on);
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_rotation(it, typed, want);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic signed [lrf_pkg::DATA_W-1:0] elem, input bit last,
                         input bit typed);
    stim_row_t row;
    row.item.element       = elem;
    row.item.final_element = last;
    row.typed              = typed;
    row.want.rotated_element = elem;
    row.want.final_result    = 1'b1;
    row.want.overflowed      = 1'b0;
    stim_rows.push_back(row);
  endtask

  // one random sequence of the given length and content
  task automatic run_sequence(input int unsigned len, input fill_e fill, input bit idle_on);
    logic signed [lrf_pkg::DATA_W-1:0] pattern[4];
    int unsigned period;
    lrf_pkg::in_item_t it;
    lrf_pkg::out_item_t none;
    none = '0;
    period = $urandom_range(1, 3);
    for (int i = 0; i < 4; i++) pattern[i] = $urandom_range(0, 2) - 32'd1;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_RANDOM: it.element = $urandom;
        FILL_NARROW: it.element = $urandom_range(0, 3) - 32'd2;
        FILL_EXTREME: begin
          case ($urandom_range(0, 4))
            0: it.element = ELEM_MIN;
            1: it.element = ELEM_MAX;
            2: it.element = '0;
            3: it.element = -32'sd1;
            default: it.element = 32'sd1;
          endcase
        end
        default: it.element = pattern[i % period];
      endcase
      it.final_element = (i == len - 1);
      send_item(it, 1'b0, none, idle_on);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe) begin
      if (pending_rotation_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_item.rotated_element, '0);
      end else begin
        oldest_r = pending_rotation_q.pop_front();
        if (out_item.rotated_element !== oldest_r.rotated_element)
          report_mismatch("rotated_element", out_item.rotated_element,
                          oldest_r.rotated_element);
        if (out_item.final_result !== oldest_r.final_result)
          report_mismatch("final_result", 32'(out_item.final_result),
                          32'(oldest_r.final_result));
        if (out_item.overflowed !== oldest_r.overflowed)
          report_mismatch("overflowed", 32'(out_item.overflowed),
                          32'(oldest_r.overflowed));
        results_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned seq_idx;
    int unsigned len;
    fill_e fill;
    bit idle_on;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-element runs at the extremes
    add_row(ELEM_MIN, 1'b1, 1'b1);
    add_row(ELEM_MAX, 1'b1, 1'b1);
    add_row(-32'sd1, 1'b1, 1'b1);
    add_row('0, 1'b1, 1'b1);
    // signed order: most negative must lead
    add_row(ELEM_MAX, 1'b0, 1'b0);
    add_row(ELEM_MIN, 1'b1, 1'b0);
    // periodic sequence, tie keeps the earliest offset
    add_row(32'sd5, 1'b0, 1'b0);
    add_row(-32'sd3, 1'b0, 1'b0);
    add_row(32'sd5, 1'b0, 1'b0);
    add_row(-32'sd3, 1'b1, 1'b0);
    // all equal
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b1, 1'b0);
    // minimum decided deep into the compare
    add_row(32'sd2, 1'b0, 1'b0);
    add_row(32'sd1, 1'b0, 1'b0);
    add_row(32'sd2, 1'b0, 1'b0);
    add_row(32'sd1, 1'b0, 1'b0);
    add_row(32'sd1, 1'b1, 1'b0);
    // wrap across the end of the buffer
    add_row('0, 1'b0, 1'b0);
    add_row(-32'sd1, 1'b0, 1'b0);
    add_row('0, 1'b1, 1'b0);
    // descending order, last offset wins
    add_row(32'sd3, 1'b0, 1'b0);
    add_row(32'sd2, 1'b0, 1'b0);
    add_row(32'sd1, 1'b1, 1'b0);

    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed,
                                     stim_rows[i].want, 1'b1);

    // random sequences: mostly short, a full buffer and two overflowing runs
    seq_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seq_idx == 3) len = MAX_LEN;
      else if (seq_idx == 9) len = MAX_LEN + 3;
      else if (seq_idx == 14) len = MAX_LEN + 2;
      else if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 16);
      fill = fill_e'($urandom_range(0, 3));
      idle_on = !(seq_idx >= 18 && seq_idx < 28);
      run_sequence(len, fill, idle_on);
      // hold off until the block has delivered everything
      if (seq_idx % 6 == 5) begin
        start <= 1'b0;
        while (pending_rotation_q.size() != 0) @(negedge clk_i);
      end
      seq_idx++;
    end
    start <= 1'b0;

    // drain
    while (pending_rotation_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rotation_q.size() != 0)
      report_mismatch("results never delivered", pending_rotation_q.size(), '0);

    $display("%0d items in %0d sequences, %0d results checked", items_sent, runs_done,
             results_checked);
    $display("%0d runs dropped elements, longest stored run %0d elements", overflow_runs,
             longest_run);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
